>>> src/ngpe_pkg.sv
// Shared constants, types and control/status bundles for the GGA position extractor.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package ngpe_pkg;

  // Field storage depth and derived widths
  localparam int FIELD_CAPACITY = 16;
  localparam int CNT_W = $clog2(FIELD_CAPACITY + 1);
  localparam int IDX_W = $clog2(FIELD_CAPACITY);

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Source of the next transmitted byte
  typedef enum logic [2:0] {
    SEL_LAT_CHAR,
    SEL_LAT_DIR,
    SEL_LF,
    SEL_LON_CHAR,
    SEL_LON_DIR
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     lat_clear;
    logic     lat_write;
    logic     lat_dir_write;
    logic     lon_clear;
    logic     lon_write;
    logic     lon_dir_write;
    logic     idx_clear;
    logic     idx_inc;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } ngpe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_dollar;
    logic is_g;
    logic is_p;
    logic is_a;
    logic is_comma;
    logic lat_full;
    logic lon_full;
    logic lat_idx_end;
    logic lon_idx_end;
    logic slot_free;
  } ngpe_sts_t;

endpackage

`default_nettype wire

>>> src/nmea_gga_position_extractor_unit.sv
// Top level of the GGA position extractor: controller plus datapath.
// Depends on ngpe_pkg, ngpe_controller and ngpe_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------
//   input   | in_valid / in_ready   | rx_byte
//   output  | out_valid / out_ready | tx_byte, last_of_run
//
// One received byte per cycle while parsing; every byte but the longitude
// direction produces no output transaction.
// After the longitude direction the input is held off while the position goes
// out: lat_count + lon_count + 4 output transactions, held back by output
// stalls; the single output register sets their pace.
// Synchronous reset returns the parser to idle with both fields empty.
`default_nettype none

module nmea_gga_position_extractor_unit
  import ngpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      tx_byte,
  output logic            last_of_run
);

  ngpe_cmd_t cmd;
  ngpe_sts_t sts;

  ngpe_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ngpe_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .sts         (sts),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

`default_nettype wire

>>> src/ngpe_datapath.sv
// Datapath: byte classification, latitude/longitude buffers, emit index and output register.
// Depends on ngpe_pkg; driven by ngpe_controller through ngpe_cmd_t.
`default_nettype none

module ngpe_datapath
  import ngpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] rx_byte,
  input  wire ngpe_cmd_t  cmd,
  output ngpe_sts_t       sts,
  output logic [7:0]      tx_byte,
  output logic            last_of_run,
  output logic            out_valid,
  input  wire logic       out_ready
);

  logic [7:0]       lat_chars [FIELD_CAPACITY];
  logic [7:0]       lon_chars [FIELD_CAPACITY];
  logic [CNT_W-1:0] lat_count;
  logic [CNT_W-1:0] lon_count;
  logic [7:0]       lat_direction;
  logic [7:0]       lon_direction;
  logic [CNT_W-1:0] emit_idx;
  logic [7:0]       out_byte_next;

  // Byte classification and counter status
  always_comb begin
    sts.is_dollar   = (rx_byte == CH_DOLLAR);
    sts.is_g        = (rx_byte == CH_G);
    sts.is_p        = (rx_byte == CH_P);
    sts.is_a        = (rx_byte == CH_A);
    sts.is_comma    = (rx_byte == CH_COMMA);
    sts.lat_full    = (lat_count == CNT_W'(FIELD_CAPACITY));
    sts.lon_full    = (lon_count == CNT_W'(FIELD_CAPACITY));
    sts.lat_idx_end = (emit_idx == lat_count);
    sts.lon_idx_end = (emit_idx == lon_count);
    sts.slot_free   = !out_valid || out_ready;
  end

  // Character buffers, written at the fill count
  always_ff @(posedge clk) begin
    if (cmd.lat_write) begin
      lat_chars[lat_count[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.lon_write) begin
      lon_chars[lon_count[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Fill counts and direction bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_count     <= '0;
      lon_count     <= '0;
      lat_direction <= '0;
      lon_direction <= '0;
    end else begin
      if (cmd.lat_clear) begin
        lat_count <= '0;
      end else if (cmd.lat_write) begin
        lat_count <= lat_count + 1'b1;
      end
      if (cmd.lon_clear) begin
        lon_count <= '0;
      end else if (cmd.lon_write) begin
        lon_count <= lon_count + 1'b1;
      end
      if (cmd.lat_dir_write) begin
        lat_direction <= rx_byte;
      end
      if (cmd.lon_dir_write) begin
        lon_direction <= rx_byte;
      end
    end
  end

  // Emit index, shared by both fields
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (cmd.idx_clear) begin
      emit_idx <= '0;
    end else if (cmd.idx_inc) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // Output byte select
  always_comb begin
    case (cmd.out_sel)
      SEL_LAT_CHAR: out_byte_next = lat_chars[emit_idx[IDX_W-1:0]];
      SEL_LAT_DIR:  out_byte_next = lat_direction;
      SEL_LON_CHAR: out_byte_next = lon_chars[emit_idx[IDX_W-1:0]];
      SEL_LON_DIR:  out_byte_next = lon_direction;
      default:      out_byte_next = CH_LF;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tx_byte     <= out_byte_next;
      last_of_run <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

>>> src/ngpe_controller.sv
// Controller: header match, field parse phases and the emit sequence.
// Depends on ngpe_pkg; commands ngpe_datapath through ngpe_cmd_t.
`default_nettype none

module ngpe_controller
  import ngpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ngpe_sts_t sts,
  output ngpe_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
    S_SKIP,
    S_LAT,
    S_LATDIR,
    S_GAP,
    S_LON,
    S_LONDIR,
    S_EM_LAT,
    S_EM_LATDIR,
    S_EM_LF1,
    S_EM_LON,
    S_EM_LONDIR,
    S_EM_LF2
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  // Input is held off only while the buffered position is sent
  always_comb begin
    unique case (state) inside
      S_EM_LAT, S_EM_LATDIR, S_EM_LF1, S_EM_LON, S_EM_LONDIR, S_EM_LF2: in_ready = 1'b0;
      default: in_ready = 1'b1;
    endcase
  end

  assign take = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel = SEL_LF;
    unique case (state)
      S_IDLE: if (take) state_next = sts.is_dollar ? S_H1 : S_IDLE;
      S_H1:   if (take) state_next = sts.is_g ? S_H2 : S_IDLE;
      S_H2:   if (take) state_next = sts.is_p ? S_H3 : S_IDLE;
      S_H3:   if (take) state_next = sts.is_g ? S_H4 : S_IDLE;
      S_H4:   if (take) state_next = sts.is_g ? S_H5 : S_IDLE;
      S_H5:   if (take) state_next = sts.is_a ? S_H6 : S_IDLE;
      S_H6:   if (take) state_next = sts.is_comma ? S_SKIP : S_IDLE;
      S_SKIP: begin
        if (take && sts.is_comma) begin
          cmd.lat_clear = 1'b1;
          state_next    = S_LAT;
        end
      end
      S_LAT: begin
        if (take) begin
          if (sts.is_comma) begin
            state_next = S_LATDIR;
          end else begin
            cmd.lat_write = !sts.lat_full;
          end
        end
      end
      S_LATDIR: begin
        if (take) begin
          cmd.lat_dir_write = 1'b1;
          state_next        = S_GAP;
        end
      end
      S_GAP: begin
        if (take) begin
          cmd.lon_clear = 1'b1;
          state_next    = S_LON;
        end
      end
      S_LON: begin
        if (take) begin
          if (sts.is_comma) begin
            state_next = S_LONDIR;
          end else begin
            cmd.lon_write = !sts.lon_full;
          end
        end
      end
      S_LONDIR: begin
        if (take) begin
          cmd.lon_dir_write = 1'b1;
          cmd.idx_clear     = 1'b1;
          state_next        = S_EM_LAT;
        end
      end
      S_EM_LAT: begin
        cmd.out_sel = SEL_LAT_CHAR;
        if (sts.lat_idx_end) begin
          state_next = S_EM_LATDIR;
        end else if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_EM_LATDIR: begin
        cmd.out_sel = SEL_LAT_DIR;
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_EM_LF1;
        end
      end
      S_EM_LF1: begin
        if (sts.slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_EM_LON;
        end
      end
      S_EM_LON: begin
        cmd.out_sel = SEL_LON_CHAR;
        if (sts.lon_idx_end) begin
          state_next = S_EM_LONDIR;
        end else if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_EM_LONDIR: begin
        cmd.out_sel = SEL_LON_DIR;
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_EM_LF2;
        end
      end
      S_EM_LF2: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_nmea_gga_position_extractor_unit.sv
`timescale 1ns / 100ps
// Testbench for nmea_gga_position_extractor_unit: a byte-level GGA parser model predicts
// every output transaction, which a scoreboard checks in order under random stalls.
// Depends on ngpe_pkg and the RTL of the extractor.

module tb_nmea_gga_position_extractor_unit;
  import ngpe_pkg::*;

  localparam int STALL_MAX      = 11;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES   = 300;
  localparam int DRAIN_CYCLES   = 16;

  // Direction letters beyond the package set
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_W = 8'h57;

  // Parser phases; the header phases are numbered by the header byte they await
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WANT_G1    = 4'd1,
    PH_WANT_P     = 4'd2,
    PH_WANT_G2    = 4'd3,
    PH_WANT_G3    = 4'd4,
    PH_WANT_A     = 4'd5,
    PH_WANT_COMMA = 4'd6,
    PH_TIME       = 4'd7,
    PH_LAT        = 4'd8,
    PH_LAT_DIR    = 4'd9,
    PH_GAP        = 4'd10,
    PH_LON        = 4'd11,
    PH_LON_DIR    = 4'd12
  } gga_phase_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_run;
  } tx_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] tx_byte;
  logic       last_of_run;

  nmea_gga_position_extractor_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state
  gga_phase_t       phase_q = PH_IDLE;
  logic [7:0]       lat_buf [FIELD_CAPACITY];
  logic [CNT_W-1:0] lat_len = '0;
  logic [7:0]       lat_dir = 8'h00;
  logic [7:0]       lon_buf [FIELD_CAPACITY];
  logic [CNT_W-1:0] lon_len = '0;
  logic [7:0]       lon_dir = 8'h00;
  tx_item_t         position_q[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  sentences_sent = 0;
  int  runs_predicted = 0;
  int  results_checked = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;
  int  out_hold = 0;
  int  quiet_cycles = 0;

  // Expected byte of "$GPGGA," at position idx
  function automatic logic [7:0] header_char(input int idx);
    case (idx)
      0:       return CH_DOLLAR;
      1:       return CH_G;
      2:       return CH_P;
      3:       return CH_G;
      4:       return CH_G;
      5:       return CH_A;
      default: return CH_COMMA;
    endcase
  endfunction

  // Any byte but a comma, as found inside a field
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_COMMA) c = c + 8'd1;
    return c;
  endfunction

  // Advance the parser model by one accepted byte; queue the position run it emits
  task automatic predict_byte(input logic [7:0] b);
    case (phase_q) inside
      PH_WANT_G1, PH_WANT_P, PH_WANT_G2, PH_WANT_G3, PH_WANT_A, PH_WANT_COMMA: begin
        if (b != header_char(int'(phase_q)))
          phase_q = PH_IDLE;
        else if (phase_q == PH_WANT_COMMA)
          phase_q = PH_TIME;
        else
          phase_q = gga_phase_t'(phase_q + 4'd1);
      end
      PH_TIME: begin
        if (b == CH_COMMA) begin
          lat_len = '0;
          phase_q = PH_LAT;
        end
      end
      PH_LAT: begin
        if (b == CH_COMMA) begin
          phase_q = PH_LAT_DIR;
        end else if (lat_len < FIELD_CAPACITY) begin
          lat_buf[lat_len] = b;
          lat_len = lat_len + 1'b1;
        end
      end
      PH_LAT_DIR: begin
        lat_dir = b;
        phase_q = PH_GAP;
      end
      PH_GAP: begin
        lon_len = '0;
        phase_q = PH_LON;
      end
      PH_LON: begin
        if (b == CH_COMMA) begin
          phase_q = PH_LON_DIR;
        end else if (lon_len < FIELD_CAPACITY) begin
          lon_buf[lon_len] = b;
          lon_len = lon_len + 1'b1;
        end
      end
      PH_LON_DIR: begin
        lon_dir = b;
        for (int k = 0; k < lat_len; k++) position_q.push_back({lat_buf[k], 1'b0});
        position_q.push_back({lat_dir, 1'b0});
        position_q.push_back({CH_LF, 1'b0});
        for (int k = 0; k < lon_len; k++) position_q.push_back({lon_buf[k], 1'b0});
        position_q.push_back({lon_dir, 1'b0});
        position_q.push_back({CH_LF, 1'b1});
        runs_predicted++;
        phase_q = PH_IDLE;
      end
      default: begin
        phase_q = (b == CH_DOLLAR) ? PH_WANT_G1 : PH_IDLE;
      end
    endcase
  endtask

  // Send one byte; valid stays up across back-to-back transactions
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Full sentence prefix up to the longitude direction, with random field content
  task automatic send_sentence(input int time_n, input int lat_n, input logic [7:0] lat_d,
                               input logic [7:0] gap_b, input int lon_n,
                               input logic [7:0] lon_d);
    for (int i = 0; i < 7; i++) send_byte(header_char(i));
    for (int i = 0; i < time_n; i++) send_byte(field_char());
    send_byte(CH_COMMA);
    for (int i = 0; i < lat_n; i++) send_byte(field_char());
    send_byte(CH_COMMA);
    send_byte(lat_d);
    send_byte(gap_b);
    for (int i = 0; i < lon_n; i++) send_byte(field_char());
    send_byte(CH_COMMA);
    send_byte(lon_d);
    sentences_sent++;
  endtask

  // Mostly a usual letter, sometimes any byte at all
  function automatic logic [7:0] pick_dir(input logic [7:0] dir_a, input logic [7:0] dir_b);
    case ($urandom_range(0, 3))
      0:       return dir_a;
      1:       return dir_b;
      2:       return 8'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? dir_a : dir_b;
    endcase
  endfunction

  // Mostly short fields, now and then past capacity
  function automatic int pick_field_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, FIELD_CAPACITY + 4);
    return $urandom_range(0, 12);
  endfunction

  // Empty time, latitude and longitude fields
  task automatic test_minimal_sentence();
    in_burst = 1'b0;
    send_sentence(0, 0, CH_N, CH_COMMA, 0, CH_E);
  endtask

  // Header broken at each position; a '$' in the middle is dropped, not a restart
  task automatic test_header_mismatch();
    in_burst = 1'b0;
    for (int i = 1; i < 7; i++) begin
      for (int j = 0; j < i; j++) send_byte(header_char(j));
      send_byte((i == 3) ? CH_DOLLAR : header_char(i) + 8'd1);
    end
    send_sentence(3, 4, CH_S, CH_COMMA, 5, CH_W);
  endtask

  // Fields at and past capacity; direction bytes at the extremes and special values
  task automatic test_field_capacity();
    in_burst = 1'b1;
    send_sentence(8, FIELD_CAPACITY, 8'h00, 8'hFF, FIELD_CAPACITY + 4, 8'hFF);
    in_burst = 1'b0;
    send_sentence(1, FIELD_CAPACITY + 3, CH_COMMA, CH_LF, FIELD_CAPACITY, CH_LF);
    send_sentence(2, 1, CH_DOLLAR, 8'h00, 1, CH_COMMA);
  endtask

  // Mostly well-formed sentences, with noise, broken headers and cut-off sentences
  task automatic test_random_stream();
    int stop_at;
    int n;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      in_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        end
        1: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) send_byte(header_char(i));
          send_byte(header_char(n) ^ 8'($urandom_range(1, 255)));
        end
        2: begin
          for (int i = 0; i < 7; i++) send_byte(header_char(i));
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) send_byte(($urandom_range(0, 2) == 0) ? CH_COMMA
                                                  : 8'($urandom_range(0, 255)));
        end
        default: begin
          send_sentence($urandom_range(0, 9), pick_field_len(), pick_dir(CH_N, CH_S),
                        ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_COMMA,
                        pick_field_len(), pick_dir(CH_E, CH_W));
        end
      endcase
    end
  endtask

  // Output side: random stall per transaction, scoreboard check on each one
  always @(posedge clk) begin : check_output
    tx_item_t want;
    int       stall;
    if (rst) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && out_ready) begin
      if (position_q.size() == 0) begin
        errors++;
        $error("unexpected output transaction: tx_byte %h last_of_run %b",
               tx_byte, last_of_run);
      end else begin
        want = position_q.pop_front();
        if (tx_byte !== want.tx_byte) begin
          errors++;
          $error("tx_byte: expected %h, got %h", want.tx_byte, tx_byte);
        end
        if (last_of_run !== want.last_of_run) begin
          errors++;
          $error("last_of_run: expected %b, got %b", want.last_of_run, last_of_run);
        end
        results_checked++;
      end
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, STALL_MAX);
      out_hold  <= stall;
      out_ready <= (stall == 0);
    end else if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[nmea_gga_position_extractor_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_minimal_sentence();
    test_header_mismatch();
    test_field_capacity();
    test_random_stream();
    in_valid <= 1'b0;
    while (position_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes holding %0d GGA sentences; checked %0d output bytes in %0d runs.",
             bytes_sent, sentences_sent, results_checked, runs_predicted);
    if (errors == 0)
      $display("[nmea_gga_position_extractor_unit] OK");
    else
      $display("[nmea_gga_position_extractor_unit] ERROR");
    $finish;
  end

endmodule
